### sv/yuvc_pkg.sv
// Shared types, constants and helpers for the YUV 4:2:0 to RGB pixel converter.
// Used by the register block, the chroma term unit, the pixel stage and the top level.
// No dependencies.
`default_nettype none

package yuvc_pkg;

	localparam int KRed = 1140;
	localparam int KGreenR = 581;
	localparam int KGreenB = 395;
	localparam int KBlue = 2032;
	localparam int TermShift = 10;
	localparam logic [7:0] KeyLevel = 8'd16;
	localparam logic [7:0] Full = 8'd255;

	localparam int AddrW = 3;
	localparam int DataW = 32;
	localparam logic RegOutputFormat = 1'b0;

	typedef enum logic {
		FMT_PACKED_RGB,
		FMT_BGRA
	} fmt_t;

	typedef struct packed {
		logic signed [8:0] red;
		logic signed [7:0] green;
		logic signed [8:0] blue;
	} chroma_terms_t;

	function automatic logic [7:0] clamp_byte(input logic signed [10:0] x);
		logic [7:0] r;
		if (x < 0) begin
			r = 8'd0;
		end else if (x > 11'sd255) begin
			r = Full;
		end else begin
			r = x[7:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### sv/yuvc_regs.sv
// APB-style configuration register block holding the output format.
// Depends on yuvc_pkg for the address width, register index and format type.
`default_nettype none

module yuvc_regs (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [yuvc_pkg::AddrW-1:0] paddr,
	input  wire logic [yuvc_pkg::DataW-1:0] pwdata,
	output logic [yuvc_pkg::DataW-1:0]  prdata,
	output logic                        pready,
	output yuvc_pkg::fmt_t              output_format
);
	import yuvc_pkg::*;

	fmt_t format_q;
	logic hit;

	assign hit = (paddr[AddrW-1] == RegOutputFormat);
	assign pready = 1'b1;
	assign output_format = format_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_PACKED_RGB;
		end else if (psel && penable && pwrite && pready && hit) begin
			format_q <= fmt_t'(pwdata[0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata[0] = format_q;
		end
	end

endmodule

`default_nettype wire

### sv/yuvc_chroma.sv
// Chroma term unit: fixed-point constant products with a floor shift on even pixels,
// held terms on odd pixels, and the pixel pair phase. Depends on yuvc_pkg.
`default_nettype none

module yuvc_chroma (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    load,
	input  wire logic [7:0]              red_chroma,
	input  wire logic [7:0]              blue_chroma,
	output yuvc_pkg::chroma_terms_t      terms
);
	import yuvc_pkg::*;

	logic pair_phase_q;
	chroma_terms_t held_q;
	chroma_terms_t fresh;
	logic signed [7:0] dr;
	logic signed [7:0] db;
	logic signed [18:0] prod_r;
	logic signed [17:0] prod_g;
	logic signed [18:0] prod_b;

	// Flipping the top bit removes the offset of 128 and yields a signed byte.
	assign dr = signed'({~red_chroma[7], red_chroma[6:0]});
	assign db = signed'({~blue_chroma[7], blue_chroma[6:0]});

	assign prod_r = 19'(dr) * 19'(KRed);
	assign prod_g = 18'(dr) * 18'(KGreenR) + 18'(db) * 18'(KGreenB);
	assign prod_b = 19'(db) * 19'(KBlue);

	assign fresh.red = 9'(prod_r >>> TermShift);
	assign fresh.green = 8'(prod_g >>> TermShift);
	assign fresh.blue = 9'(prod_b >>> TermShift);

	assign terms = pair_phase_q ? held_q : fresh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_phase_q <= 1'b0;
			held_q <= '0;
		end else if (load) begin
			pair_phase_q <= ~pair_phase_q;
			if (!pair_phase_q) begin
				held_q <= fresh;
			end
		end
	end

	a_phase_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> pair_phase_q != $past(pair_phase_q))
		else $error("pair phase did not toggle on a transaction");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> $stable(pair_phase_q) && $stable(held_q))
		else $error("chroma state changed without a transaction");

	a_odd_keeps_terms: assert property (@(posedge clk) disable iff (!arst_n)
		load && pair_phase_q |=> $stable(held_q))
		else $error("held terms changed on an odd pixel");

endmodule

`default_nettype wire

### sv/yuvc_pixel.sv
// Result stage: sums luma+red, luma-green, luma+blue terms, clamps, forms alpha, registers.
// Depends on yuvc_pkg for the term struct, format type and clamp helper.
`default_nettype none

module yuvc_pixel (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    load,
	input  wire logic [7:0]              luma,
	input  wire yuvc_pkg::chroma_terms_t terms,
	input  wire yuvc_pkg::fmt_t          output_format,
	input  wire logic                    ready,
	output logic                         valid,
	output logic [7:0]                   red,
	output logic [7:0]                   green,
	output logic [7:0]                   blue,
	output logic [7:0]                   alpha
);
	import yuvc_pkg::*;

	logic valid_s2;
	logic [7:0] red_s2;
	logic [7:0] green_s2;
	logic [7:0] blue_s2;
	logic [7:0] alpha_s2;
	logic signed [10:0] y_ext;
	logic [7:0] alpha_next;

	assign y_ext = signed'({3'b000, luma});

	always_comb begin
		if (output_format == FMT_PACKED_RGB) begin
			alpha_next = Full;
		end else if (luma < KeyLevel) begin
			alpha_next = 8'd0;
		end else begin
			alpha_next = Full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			red_s2 <= clamp_byte(y_ext + 11'(terms.red));
			green_s2 <= clamp_byte(y_ext - 11'(terms.green));
			blue_s2 <= clamp_byte(y_ext + 11'(terms.blue));
			alpha_s2 <= alpha_next;
		end
	end

	assign valid = valid_s2;
	assign red = red_s2;
	assign green = green_s2;
	assign blue = blue_s2;
	assign alpha = alpha_s2;

	a_alpha_binary: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (alpha_s2 == 8'd0 || alpha_s2 == Full))
		else $error("alpha is neither transparent nor opaque");

endmodule

`default_nettype wire

### sv/yuv_to_rgb_pixel_converter.sv
// Top level of the YUV 4:2:0 to RGB pixel converter.
// Depends on yuvc_pkg, yuvc_regs, yuvc_chroma and yuvc_pixel.
//
// One pixel enters per input transaction on in_valid/in_ready with its luma byte
// and the two chroma bytes of its 4:2:0 sample; one RGBA result leaves per output
// transaction on out_valid/out_ready. Pixels alternate even and odd: an even pixel
// computes fresh chroma terms from its chroma bytes, the following odd pixel reuses
// them and its chroma bytes are ignored. The phase runs freely across rows.
// The pixel is captured in an input register, the terms, sums and clamps are formed
// in one combinational stage, and the result is held in an output register, so one
// pixel is taken per cycle as long as a low out_ready does not stall the output.
// When out_ready is low the result stays in place; the input register still takes one
// more pixel, after which in_ready drops until the result is taken.
// The APB port holds output_format at address 0: 0 gives packed RGB with alpha
// forced to 255, 1 gives BGRA with alpha 0 for luma below 16. Write it only when
// the block is empty. Reset empties both registers, clears the held terms,
// starts on an even pixel and selects packed RGB.
`default_nettype none

module yuv_to_rgb_pixel_converter (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [yuvc_pkg::AddrW-1:0] paddr,
	input  wire logic [yuvc_pkg::DataW-1:0] pwdata,
	output logic [yuvc_pkg::DataW-1:0]      prdata,
	output logic                            pready,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [7:0]                 luma,
	input  wire logic [7:0]                 red_chroma,
	input  wire logic [7:0]                 blue_chroma,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [7:0]                      red,
	output logic [7:0]                      green,
	output logic [7:0]                      blue,
	output logic [7:0]                      alpha
);
	import yuvc_pkg::*;

	fmt_t output_format;
	chroma_terms_t terms;
	logic valid_s1;
	logic [7:0] luma_s1;
	logic [7:0] red_chroma_s1;
	logic [7:0] blue_chroma_s1;
	logic advance;
	logic load;

	assign advance = !out_valid || out_ready;
	assign load = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			luma_s1 <= luma;
			red_chroma_s1 <= red_chroma;
			blue_chroma_s1 <= blue_chroma;
		end
	end

	yuvc_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.output_format (output_format)
	);

	yuvc_chroma u_chroma (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.red_chroma  (red_chroma_s1),
		.blue_chroma (blue_chroma_s1),
		.terms       (terms)
	);

	yuvc_pixel u_pixel (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.luma          (luma_s1),
		.terms         (terms),
		.output_format (output_format),
		.ready         (out_ready),
		.valid         (out_valid),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.alpha         (alpha)
	);

	a_load_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid)
		else $error("result register empty after a transfer into it");

	a_stall_blocks_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !load)
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire
